@@ rtl/sem_pkg.sv @@
// Package for the RGB Sobel edge magnitude block: frame limits, field widths,
// pixel type and the controller state codes. No dependencies.
package sem_pkg;

	localparam int MAX_WIDTH  = 1024;
	localparam int MAX_HEIGHT = 1024;

	localparam int COL_W  = $clog2(MAX_WIDTH);
	localparam int ROW_W  = $clog2(MAX_HEIGHT + 2);
	localparam int REG_W  = 11;
	localparam int PIX_W  = 24;
	localparam int GRAD_W = 11;
	localparam int SQ_W   = 21;

	localparam logic [SQ_W-1:0] SQ_CLAMP = SQ_W'(65280);

	localparam logic CFG_LINE_WIDTH   = 1'b0;
	localparam logic CFG_FRAME_HEIGHT = 1'b1;

	typedef logic [PIX_W-1:0] pixel_t;
	typedef logic signed [GRAD_W-1:0] grad_t;

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_MEM  = 3'd1;
	localparam logic [2:0] ST_SQ   = 3'd2;
	localparam logic [2:0] ST_ROOT = 3'd3;
	localparam logic [2:0] ST_FIN  = 3'd4;

endpackage

@@ rtl/sobel_edge_magnitude_rgb.sv @@
// Sobel edge magnitude on an RGB raster stream, with two line memories.
// Depends on sem_pkg.
//
// One item is in flight at a time. An item that yields no result goes through
// the accept and window steps only; an item that yields one goes through them
// all, in order: the accept step, which also reads the line memories; the window
// step, which updates the window and forms Gx and Gy; the squares; a bit-wise
// square root, one result bit per step on logic shared over its steps; and rounding
// into the output register. The rounding step waits while the previous result has
// not yet been collected. The result waits in an output register, so the next
// item is taken while it is not yet collected. The result for raster index k
// comes with item k + width + 1. A frame is width*height pixel items then
// width + 1 drain items. Any register write restarts the frame.
module sobel_edge_magnitude_rgb (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_ready,
	input  logic                      mode,
	input  logic [7:0]                red_in,
	input  logic [7:0]                green_in,
	input  logic [7:0]                blue_in,
	output logic                      out_valid,
	input  logic                      out_ready,
	output logic [7:0]                red_edge,
	output logic [7:0]                green_edge,
	output logic [7:0]                blue_edge,
	output logic                      frame_end,
	input  logic                      cfg_valid,
	output logic                      cfg_ready,
	input  logic                      cfg_index,
	input  logic [sem_pkg::REG_W-1:0] cfg_data
);
	import sem_pkg::*;

	logic [2:0]       state_q;
	logic [REG_W-1:0] width_reg_q, height_reg_q;
	logic [REG_W-1:0] w_used, h_used;
	logic [COL_W-1:0] col_q, ic_now, ic_s1;
	logic [ROW_W-1:0] row_q;
	pixel_t           pix_s1;
	logic             mode_s1;

	pixel_t upper_mem [MAX_WIDTH];
	pixel_t middle_mem [MAX_WIDTH];
	pixel_t up_rd_q, mid_rd_q;

	pixel_t win_q [9];
	pixel_t top, mid, bot;
	pixel_t cw [9];
	logic   center_zero, emit, last;

	grad_t          gx_q [3];
	grad_t          gy_q [3];
	logic [SQ_W-1:0] sq_q [3];
	logic [7:0]     q_q [3];
	logic [7:0]     res [3];
	logic [2:0]     step_q;
	logic           last_q;
	logic           in_fire, out_free;

	always_comb begin
		w_used = (width_reg_q == '0) ? REG_W'(1)
			: (width_reg_q > REG_W'(MAX_WIDTH)) ? REG_W'(MAX_WIDTH) : width_reg_q;
		h_used = (height_reg_q == '0) ? REG_W'(1)
			: (height_reg_q > REG_W'(MAX_HEIGHT)) ? REG_W'(MAX_HEIGHT) : height_reg_q;
		ic_now = (REG_W'(col_q) >= w_used) ? '0 : col_q;
	end

	// a register write takes priority over a pixel transfer
	assign in_ready  = (state_q == ST_IDLE) && !cfg_valid;
	assign cfg_ready = (state_q == ST_IDLE);
	assign in_fire   = in_valid && in_ready;
	assign out_free  = !out_valid || out_ready;

	// line memories: read on accept, write back once the item is resolved
	always_ff @(posedge clk) begin
		if (in_fire) begin
			up_rd_q  <= upper_mem[ic_now];
			mid_rd_q <= middle_mem[ic_now];
		end
		if (state_q == ST_MEM) begin
			upper_mem[ic_s1]  <= mid;
			middle_mem[ic_s1] <= bot;
		end
	end

	always_comb begin
		bot = (ROW_W'(h_used) > row_q && !mode_s1) ? pix_s1 : '0;
		mid = (row_q >= ROW_W'(1)) ? mid_rd_q : '0;
		top = (row_q >= ROW_W'(2)) ? up_rd_q : '0;
		center_zero = (ic_s1 == '0) ? (w_used == REG_W'(1)) : (ic_s1 == COL_W'(1));
		for (int r = 0; r < 3; r++) begin
			cw[r*3]   = center_zero ? '0 : win_q[r*3+1];
			cw[r*3+1] = win_q[r*3+2];
		end
		cw[2] = (ic_s1 != '0) ? top : '0;
		cw[5] = (ic_s1 != '0) ? mid : '0;
		cw[8] = (ic_s1 != '0) ? bot : '0;
		emit = (row_q >= ROW_W'(2)) || (row_q == ROW_W'(1) && ic_s1 != '0);
		last = (row_q == ROW_W'(h_used) + ROW_W'(1)) && (ic_s1 == '0);
	end

	function automatic logic [GRAD_W-1:0] ch(input pixel_t p, input int c);
		return GRAD_W'(p[8*c +: 8]);
	endfunction

	always_comb begin
		for (int r = 0; r < 3; r++) begin
			res[r] = '0;
		end
		for (int c = 0; c < 3; c++) begin
			logic [SQ_W-1:0] lim;
			lim = SQ_W'(q_q[c]) * SQ_W'(q_q[c]) + SQ_W'(q_q[c]);
			if (sq_q[c] > SQ_CLAMP) begin
				res[c] = 8'd255;
			end else if (sq_q[c] > lim) begin
				res[c] = q_q[c] + 8'd1;
			end else begin
				res[c] = q_q[c];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			width_reg_q  <= REG_W'(MAX_WIDTH);
			height_reg_q <= REG_W'(MAX_HEIGHT);
			col_q        <= '0;
			row_q        <= '0;
			out_valid    <= 1'b0;
			last_q       <= 1'b0;
			step_q       <= '0;
			for (int i = 0; i < 9; i++) begin
				win_q[i] <= '0;
			end
		end else begin
			if (out_valid && out_ready && state_q != ST_FIN) begin
				out_valid <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (cfg_valid) begin
						if (cfg_index == CFG_LINE_WIDTH) begin
							width_reg_q <= cfg_data;
						end else begin
							height_reg_q <= cfg_data;
						end
						col_q <= '0;
						row_q <= '0;
						for (int i = 0; i < 9; i++) begin
							win_q[i] <= '0;
						end
					end else if (in_valid) begin
						ic_s1   <= ic_now;
						pix_s1  <= {blue_in, green_in, red_in};
						mode_s1 <= mode;
						state_q <= ST_MEM;
					end
				end
				ST_MEM: begin
					for (int c = 0; c < 3; c++) begin
						grad_t gx, gy;
						gx = grad_t'((ch(cw[2], c) + (ch(cw[5], c) << 1) + ch(cw[8], c))
							- (ch(cw[0], c) + (ch(cw[3], c) << 1) + ch(cw[6], c)));
						gy = grad_t'((ch(cw[6], c) + (ch(cw[7], c) << 1) + ch(cw[8], c))
							- (ch(cw[0], c) + (ch(cw[1], c) << 1) + ch(cw[2], c)));
						gx_q[c] <= gx;
						gy_q[c] <= gy;
					end
					last_q <= last;
					if (last) begin
						col_q <= '0;
						row_q <= '0;
						for (int i = 0; i < 9; i++) begin
							win_q[i] <= '0;
						end
					end else begin
						for (int r = 0; r < 3; r++) begin
							win_q[r*3]   <= win_q[r*3+1];
							win_q[r*3+1] <= win_q[r*3+2];
						end
						win_q[2] <= top;
						win_q[5] <= mid;
						win_q[8] <= bot;
						if (REG_W'(ic_s1) + REG_W'(1) >= w_used) begin
							col_q <= '0;
							row_q <= row_q + ROW_W'(1);
						end else begin
							col_q <= ic_s1 + COL_W'(1);
						end
					end
					state_q <= emit ? ST_SQ : ST_IDLE;
				end
				ST_SQ: begin
					for (int c = 0; c < 3; c++) begin
						sq_q[c] <= SQ_W'(gx_q[c] * gx_q[c]) + SQ_W'(gy_q[c] * gy_q[c]);
						q_q[c]  <= '0;
					end
					step_q  <= '0;
					state_q <= ST_ROOT;
				end
				ST_ROOT: begin
					// one result bit per cycle, most significant first
					for (int c = 0; c < 3; c++) begin
						logic [7:0] t;
						t = q_q[c] | (8'h80 >> step_q);
						if (SQ_W'(t) * SQ_W'(t) <= sq_q[c]) begin
							q_q[c] <= t;
						end
					end
					step_q <= step_q + 3'd1;
					if (step_q == 3'd7) begin
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					// hold until the output register is free
					if (out_free) begin
						red_edge   <= res[0];
						green_edge <= res[1];
						blue_edge  <= res[2];
						frame_end  <= last_q;
						out_valid  <= 1'b1;
						state_q    <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule
